@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the top unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define RBST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never hold
`define RBST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/core/rbst_pkg.sv @@
// ----------------------------------------------------------------------------
// rbst_pkg
// types, constants and latencies of the ray box slab test unit
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int CW       = 32;
    localparam int FRAC     = 16;
    localparam int CFG_W    = 17;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT  = DIV_STEPS + 3;
    localparam int RED_LAT  = 4;
    localparam int HIT_LAT  = 4;
    localparam int SIDE_LAT = DIV_LAT + RED_LAT;
    localparam int TOTAL_LAT = 1 + DIV_LAT + RED_LAT + HIT_LAT;

    typedef logic signed [CW-1:0] t_coord;

    localparam logic [2:0] FACE_NEG_X = 3'd0;
    localparam logic [2:0] FACE_POS_X = 3'd1;
    localparam logic [2:0] FACE_NEG_Y = 3'd2;
    localparam logic [2:0] FACE_POS_Y = 3'd3;
    localparam logic [2:0] FACE_NEG_Z = 3'd4;
    localparam logic [2:0] FACE_POS_Z = 3'd5;

    localparam logic CFG_IDX_TOL = 1'b0;
    localparam logic CFG_IDX_SUB = 1'b1;

    localparam logic [CFG_W-1:0] TOL_RESET = 17'd16;
    localparam logic [CFG_W-1:0] SUB_RESET = 17'd1;

    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord DIST_MISS = -(t_coord'(1) <<< FRAC);
    localparam logic [CW:0] MAG_LIMIT = {2'b01, {(CW-1){1'b0}}};

    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord origin_z;
        t_coord direction_x;
        t_coord direction_y;
        t_coord direction_z;
        t_coord box_min_x;
        t_coord box_min_y;
        t_coord box_min_z;
        t_coord box_max_x;
        t_coord box_max_y;
        t_coord box_max_z;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        t_coord     distance;
        t_coord     point_x;
        t_coord     point_y;
        t_coord     point_z;
        logic [2:0] face;
    } t_out_item;

    typedef struct packed {
        t_coord [2:0] org;
        t_coord [2:0] dir;
    } t_side;

    typedef struct packed {
        logic       miss;
        t_coord     t;
        logic [2:0] face;
    } t_red;

    // magnitude saturated to the signed range with sign applied
    function automatic t_coord apply_sign(input logic [CW:0] m, input logic neg);
        logic [CW:0] v;
        v = neg ? (~m + 1'b1) : m;
        if (!neg && m >= MAG_LIMIT) begin
            return COORD_MAX;
        end
        return t_coord'(v[CW-1:0]);
    endfunction

endpackage

@@ rtl/core/rbst_divider.sv @@
// ----------------------------------------------------------------------------
// rbst_divider
// pipelined fixed point divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbst_divider (
    input  logic            i_clk,
    input  logic signed [rbst_pkg::CW:0] i_num,
    input  rbst_pkg::t_coord i_den,
    output rbst_pkg::t_coord o_quo
);
    import rbst_pkg::*;

    logic [CW:0]   r_un;
    logic [CW-1:0] r_ud0;
    logic          r_neg0;

    logic [CW-1:0] r_rem [0:DIV_STEPS];
    logic [CW-1:0] r_low [0:DIV_STEPS];
    logic [CW-1:0] r_q   [0:DIV_STEPS];
    logic [CW-1:0] r_ud  [0:DIV_STEPS];
    logic          r_ovf [0:DIV_STEPS];
    logic          r_neg [0:DIV_STEPS];

    logic [CW:0]   n_m;
    t_coord        r_quo;

    always_ff @(posedge i_clk) begin
        r_un   <= i_num[CW] ? (~i_num + 1'b1) : i_num;
        r_ud0  <= i_den[CW-1] ? (~i_den + 1'b1) : i_den;
        r_neg0 <= i_num[CW] ^ i_den[CW-1];
    end

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= {(FRAC-1)'(0), r_un} >= {r_ud0, FRAC'(0)};
        r_rem[0] <= {(CW-(CW+1-FRAC))'(0), r_un[CW:FRAC]};
        r_low[0] <= {r_un[FRAC-1:0], FRAC'(0)};
        r_q[0]   <= '0;
        r_ud[0]  <= r_ud0;
        r_neg[0] <= r_neg0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [CW:0] n_rem2;
        logic        n_ge;
        always_comb begin
            n_rem2 = {r_rem[k], r_low[k][CW-1]};
            n_ge   = n_rem2 >= {1'b0, r_ud[k]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? CW'(n_rem2 - {1'b0, r_ud[k]}) : n_rem2[CW-1:0];
            r_low[k+1] <= {r_low[k][CW-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][CW-2:0], n_ge};
            r_ud[k+1]  <= r_ud[k];
            r_ovf[k+1] <= r_ovf[k];
            r_neg[k+1] <= r_neg[k];
        end
    end

    always_comb begin
        if (r_ovf[DIV_STEPS] || {1'b0, r_q[DIV_STEPS]} > MAG_LIMIT) begin
            n_m = MAG_LIMIT;
        end else begin
            n_m = {1'b0, r_q[DIV_STEPS]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= apply_sign(n_m, r_neg[DIV_STEPS]);
    end

    assign o_quo = r_quo;

endmodule

@@ rtl/core/rbst_slab_reduce.sv @@
// ----------------------------------------------------------------------------
// rbst_slab_reduce
// near and far distances, miss decision, t and face selection
// ----------------------------------------------------------------------------
module rbst_slab_reduce (
    input  logic                      i_clk,
    input  rbst_pkg::t_coord [5:0]    i_slab,
    input  logic [rbst_pkg::CFG_W-1:0] i_tol,
    output rbst_pkg::t_red            o_red
);
    import rbst_pkg::*;

    t_coord [5:0] r_slab1, r_slab2, r_slab3;
    t_coord [2:0] r_lo, r_hi;
    t_coord       r_near, r_far, r_t;
    logic         r_miss;
    t_red         r_red;
    logic [2:0]   n_face;
    logic signed [CW:0] n_diff;
    logic [CW:0]  n_mag;

    always_ff @(posedge i_clk) begin
        r_slab1 <= i_slab;
        for (int a = 0; a < 3; a++) begin
            if (i_slab[2*a] < i_slab[2*a+1]) begin
                r_lo[a] <= i_slab[2*a];
                r_hi[a] <= i_slab[2*a+1];
            end else begin
                r_lo[a] <= i_slab[2*a+1];
                r_hi[a] <= i_slab[2*a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        t_coord mx, mn;
        mx = r_lo[0];
        mn = r_hi[0];
        if (r_lo[1] > mx) mx = r_lo[1];
        if (r_lo[2] > mx) mx = r_lo[2];
        if (r_hi[1] < mn) mn = r_hi[1];
        if (r_hi[2] < mn) mn = r_hi[2];
        r_near  <= mx;
        r_far   <= mn;
        r_slab2 <= r_slab1;
    end

    always_ff @(posedge i_clk) begin
        r_miss  <= (r_far < 0) || (r_near > r_far);
        r_t     <= (r_near < 0) ? r_far : r_near;
        r_slab3 <= r_slab2;
    end

    always_comb begin
        n_face = FACE_POS_Z;
        n_diff = '0;
        n_mag  = '0;
        for (int i = 0; i < 6; i++) begin
            n_diff = (CW+1)'(r_t) - (CW+1)'(r_slab3[i]);
            n_mag  = n_diff[CW] ? (~n_diff + 1'b1) : n_diff;
            if (n_mag <= {(CW+1-CFG_W)'(0), i_tol}) begin
                n_face = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_red.miss <= r_miss;
        r_red.t    <= r_t;
        r_red.face <= n_face;
    end

    assign o_red = r_red;

endmodule

@@ rtl/core/rbst_hit_point.sv @@
// ----------------------------------------------------------------------------
// rbst_hit_point
// hit point origin + direction * t with saturation, result formatting
// ----------------------------------------------------------------------------
module rbst_hit_point (
    input  logic                i_clk,
    input  rbst_pkg::t_side     i_side,
    input  rbst_pkg::t_red      i_red,
    output rbst_pkg::t_out_item o_result
);
    import rbst_pkg::*;

    logic [2:0][CW-1:0]   r_ud;
    logic [CW-1:0]        r_ut;
    logic [2:0]           r_neg1, r_neg2;
    logic [2:0][2*CW-1:0] r_prod;
    t_coord [2:0]         r_val;
    t_coord [2:0]         r_org1, r_org2, r_org3;
    t_red                 r_red1, r_red2, r_red3;
    t_out_item            r_out;

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_ud[a]   <= i_side.dir[a][CW-1] ? (~i_side.dir[a] + 1'b1) : i_side.dir[a];
            r_neg1[a] <= i_side.dir[a][CW-1] ^ i_red.t[CW-1];
        end
        r_ut   <= i_red.t[CW-1] ? (~i_red.t + 1'b1) : i_red.t;
        r_org1 <= i_side.org;
        r_red1 <= i_red;
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_prod[a] <= {CW'(0), r_ud[a]} * {CW'(0), r_ut};
        end
        r_neg2 <= r_neg1;
        r_org2 <= r_org1;
        r_red2 <= r_red1;
    end

    always_ff @(posedge i_clk) begin
        logic [CW:0] m;
        for (int a = 0; a < 3; a++) begin
            if (r_prod[a][2*CW-1:CW+FRAC] != '0) begin
                m = MAG_LIMIT;
            end else begin
                m = {1'b0, r_prod[a][CW+FRAC-1:FRAC]};
                if (m > MAG_LIMIT) m = MAG_LIMIT;
            end
            r_val[a] <= apply_sign(m, r_neg2[a]);
        end
        r_org3 <= r_org2;
        r_red3 <= r_red2;
    end

    always_ff @(posedge i_clk) begin
        logic signed [CW:0] s;
        t_coord [2:0] p;
        for (int a = 0; a < 3; a++) begin
            s = (CW+1)'(r_org3[a]) + (CW+1)'(r_val[a]);
            if (s > (CW+1)'(COORD_MAX)) begin
                p[a] = COORD_MAX;
            end else if (s < (CW+1)'(COORD_MIN)) begin
                p[a] = COORD_MIN;
            end else begin
                p[a] = t_coord'(s[CW-1:0]);
            end
        end
        if (r_red3.miss) begin
            r_out.hit      <= 1'b0;
            r_out.distance <= DIST_MISS;
            r_out.point_x  <= '0;
            r_out.point_y  <= '0;
            r_out.point_z  <= '0;
            r_out.face     <= FACE_POS_Z;
        end else begin
            r_out.hit      <= 1'b1;
            r_out.distance <= r_red3.t;
            r_out.point_x  <= p[0];
            r_out.point_y  <= p[1];
            r_out.point_z  <= p[2];
            r_out.face     <= r_red3.face;
        end
    end

    assign o_result = r_out;

endmodule

@@ rtl/core/ray_box_slab_test_unit.sv @@
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// ray against axis-aligned box, slab method, signed Q16.16
// ----------------------------------------------------------------------------
// Takes one ray/box test per clock and never stalls: busy stays low. Each
// result appears on o_result with o_done high for one cycle. The latency is
// set by the six parallel dividers, which produce one quotient bit per
// pipeline stage (32 stages plus setup and saturation), followed by the
// reduce and hit point multiplier pipelines.
// Configuration must be written while no test is in flight.
`include "assert_macros.svh"

module ray_box_slab_test_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  rbst_pkg::t_in_item           i_item,
    output logic                         o_done,
    output rbst_pkg::t_out_item          o_result,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [rbst_pkg::CFG_W-1:0]   i_cfg_data
);
    import rbst_pkg::*;

    logic [CFG_W-1:0]     r_tol, r_sub;
    logic [TOTAL_LAT-1:0] r_vld;
    t_in_item             r_in;
    t_side                r_side [0:SIDE_LAT-1];
    logic [CFG_W-1:0]     n_sub;
    t_coord [2:0]         n_org, n_dir, n_bmin, n_bmax, n_den;
    t_coord [5:0]         n_slab;
    t_red                 n_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_sub <= SUB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_TOL: r_tol <= i_cfg_data;
                CFG_IDX_SUB: r_sub <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_start && !o_busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    always_comb begin
        n_sub  = (r_sub == '0) ? CFG_W'(1) : r_sub;
        n_org  = {r_in.origin_z, r_in.origin_y, r_in.origin_x};
        n_dir  = {r_in.direction_z, r_in.direction_y, r_in.direction_x};
        n_bmin = {r_in.box_min_z, r_in.box_min_y, r_in.box_min_x};
        n_bmax = {r_in.box_max_z, r_in.box_max_y, r_in.box_max_x};
        for (int a = 0; a < 3; a++) begin
            n_den[a] = (n_dir[a] == '0) ? t_coord'({(CW-CFG_W)'(0), n_sub}) : n_dir[a];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_divider u_div_min (
            .i_clk (i_clk),
            .i_num ((CW+1)'(n_bmin[a]) - (CW+1)'(n_org[a])),
            .i_den (n_den[a]),
            .o_quo (n_slab[2*a])
        );
        rbst_divider u_div_max (
            .i_clk (i_clk),
            .i_num ((CW+1)'(n_bmax[a]) - (CW+1)'(n_org[a])),
            .i_den (n_den[a]),
            .o_quo (n_slab[2*a+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_side[0].org <= n_org;
        r_side[0].dir <= n_dir;
        for (int k = 1; k < SIDE_LAT; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    rbst_slab_reduce u_reduce (
        .i_clk  (i_clk),
        .i_slab (n_slab),
        .i_tol  (r_tol),
        .o_red  (n_red)
    );

    rbst_hit_point u_hit (
        .i_clk    (i_clk),
        .i_side   (r_side[SIDE_LAT-1]),
        .i_red    (n_red),
        .o_result (o_result)
    );

    assign o_busy = 1'b0;
    assign o_done = r_vld[TOTAL_LAT-1];

    `RBST_ASSERT_IMPL(a_miss_format, i_clk, i_rst_n, o_done && !o_result.hit, o_result.distance == DIST_MISS && o_result.face == FACE_POS_Z && o_result.point_x == '0)
    `RBST_ASSERT_IMPL(a_hit_nonneg, i_clk, i_rst_n, o_done && o_result.hit, !o_result.distance[CW-1])
    `RBST_ASSERT_NEVER(a_face_range, i_clk, i_rst_n, o_done && o_result.face > FACE_POS_Z)

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking regression of the ray box slab test unit
// ----------------------------------------------------------------------------
// Rays and boxes are queued by an initial block and sent by a clocked driver
// with random gaps. A fixed point slab predictor computes each expected hit
// record at the start transfer. A clocked monitor compares every done
// transfer with the oldest expected record. Tolerance and zero substitute
// are changed between phases while the unit is idle.
`timescale 1ns / 1ps

module testbench;
    import rbst_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    t_in_item   i_item;
    logic       o_done;
    t_out_item  o_result;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    ray_box_slab_test_unit dut (.*);

    t_in_item   ray_queue[$];
    t_out_item  hit_queue[$];
    logic [CFG_W-1:0] tolerance;
    logic [CFG_W-1:0] substitute;
    int         gap_left;
    int         error_count;
    int         sent_count;
    int         checked_count;
    int         hit_count;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [CW:0] coord_mag(input longint v);
        return (v < 0) ? (CW+1)'(-v) : (CW+1)'(v);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
        return v;
    endfunction

    function automatic longint slab_quotient(input longint num, input longint den);
        logic [63:0] un, ud, q0, r, frac, m;
        logic neg;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        q0 = un / ud;
        r = un % ud;
        frac = 0;
        if (q0 > (64'd1 << (CW - 1 - FRAC))) begin
            m = 64'd1 << (CW - 1);
        end else begin
            for (int i = 0; i < FRAC; i++) begin
                r = r << 1;
                frac = frac << 1;
                if (r >= ud) begin
                    r = r - ud;
                    frac[0] = 1'b1;
                end
            end
            m = (q0 << FRAC) | frac;
            if (m > (64'd1 << (CW - 1))) m = 64'd1 << (CW - 1);
        end
        return clamp_coord(neg ? -longint'(m) : longint'(m));
    endfunction

    function automatic longint scaled_product(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0] ua, ub, m;
        logic neg;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        p = ua * ub;
        if ((p >> (64 + FRAC)) != 0) begin
            m = 64'd1 << (CW - 1);
        end else begin
            m = p[FRAC +: 64];
            if (m > (64'd1 << (CW - 1))) m = 64'd1 << (CW - 1);
        end
        return clamp_coord(neg ? -longint'(m) : longint'(m));
    endfunction

    function automatic t_out_item predict_hit(input t_in_item it);
        t_out_item res;
        longint org[3], dir[3], bmin[3], bmax[3], slab[6];
        longint den, sub, near, far, lo, hi, t;
        logic [2:0] face;
        org = '{it.origin_x, it.origin_y, it.origin_z};
        dir = '{it.direction_x, it.direction_y, it.direction_z};
        bmin = '{it.box_min_x, it.box_min_y, it.box_min_z};
        bmax = '{it.box_max_x, it.box_max_y, it.box_max_z};
        sub = (substitute == 0) ? 1 : longint'(substitute);
        for (int a = 0; a < 3; a++) begin
            den = (dir[a] == 0) ? sub : dir[a];
            slab[2*a] = slab_quotient(bmin[a] - org[a], den);
            slab[2*a+1] = slab_quotient(bmax[a] - org[a], den);
        end
        for (int a = 0; a < 3; a++) begin
            lo = (slab[2*a] < slab[2*a+1]) ? slab[2*a] : slab[2*a+1];
            hi = (slab[2*a] < slab[2*a+1]) ? slab[2*a+1] : slab[2*a];
            if (a == 0 || lo > near) near = lo;
            if (a == 0 || hi < far) far = hi;
        end
        res = '0;
        res.face = FACE_POS_Z;
        if (far < 0 || near > far) begin
            res.distance = DIST_MISS;
            return res;
        end
        t = (near < 0) ? far : near;
        face = FACE_POS_Z;
        for (int i = 0; i < 6; i++) begin
            if (coord_mag(t - slab[i]) <= tolerance) face = 3'(i);
        end
        res.hit = 1'b1;
        res.distance = t_coord'(t);
        res.point_x = t_coord'(clamp_coord(org[0] + scaled_product(dir[0], t)));
        res.point_y = t_coord'(clamp_coord(org[1] + scaled_product(dir[1], t)));
        res.point_z = t_coord'(clamp_coord(org[2] + scaled_product(dir[2], t)));
        res.face = face;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return t_coord'($signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000);
        if (r == 5) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        if (r == 6) return '0;
        return t_coord'($urandom());
    endfunction

    // ray pointed at a small box, with random content; some directions are zeroed or negated, some boxes inverted in y
    function automatic t_in_item aimed_ray();
        t_in_item it;
        t_coord c[3], h[3], o[3], d[3];
        for (int a = 0; a < 3; a++) begin
            c[a] = t_coord'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
            h[a] = t_coord'($urandom_range(32'h0000_1000, 32'h0004_0000));
            o[a] = t_coord'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            d[a] = t_coord'((c[a] - o[a]) >>> $urandom_range(0, 4));
            if ($urandom_range(0, 7) == 0) d[a] = '0;
            if ($urandom_range(0, 7) == 0) d[a] = -d[a];
        end
        it.origin_x = o[0];
        it.origin_y = o[1];
        it.origin_z = o[2];
        it.direction_x = d[0];
        it.direction_y = d[1];
        it.direction_z = d[2];
        it.box_min_x = c[0] - h[0];
        it.box_min_y = c[1] - h[1];
        it.box_min_z = c[2] - h[2];
        it.box_max_x = c[0] + h[0];
        it.box_max_y = c[1] + h[1];
        it.box_max_z = c[2] + h[2];
        if ($urandom_range(0, 9) == 0) begin
            it.box_min_y = c[1] + h[1];
            it.box_max_y = c[1] - h[1];
        end
        return it;
    endfunction

    function automatic t_in_item noise_ray();
        t_in_item it;
        it = t_in_item'({$urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom()});
        if ($urandom_range(0, 1)) begin
            it.origin_x = rand_coord();
            it.direction_y = rand_coord();
            it.box_min_z = rand_coord();
            it.box_max_x = rand_coord();
        end
        return it;
    endfunction

    function automatic t_in_item unit_ray(input t_coord ox, input t_coord dx,
                                          input t_coord dy, input t_coord dz);
        t_in_item it;
        it.origin_x = ox;
        it.origin_y = '0;
        it.origin_z = '0;
        it.direction_x = dx;
        it.direction_y = dy;
        it.direction_z = dz;
        it.box_min_x = 32'sh0001_0000;
        it.box_min_y = -32'sh0001_0000;
        it.box_min_z = -32'sh0001_0000;
        it.box_max_x = 32'sh0003_0000;
        it.box_max_y = 32'sh0001_0000;
        it.box_max_z = 32'sh0001_0000;
        return it;
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_IDX_TOL) tolerance = val;
        else substitute = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (ray_queue.size() != 0 || hit_queue.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 4) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_start && !o_busy) begin
                hit_queue.push_back(predict_hit(i_item));
                sent_count++;
                void'(ray_queue.pop_front());
            end
            if (i_start && o_busy) begin
                i_start <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
            end else if (ray_queue.size() > ((i_start && !o_busy) ? 0 : 0)) begin
                i_start <= 1'b1;
                i_item <= ray_queue[0];
                gap_left <= pick_gap();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                error_count++;
            end else begin
                want = hit_queue.pop_front();
                checked_count++;
                if (o_result.hit) hit_count++;
                if (o_result.hit !== want.hit)
                    $display("%0t: hit expected %b actual %b", $time, want.hit, o_result.hit);
                if (o_result.distance !== want.distance)
                    $display("%0t: distance expected %h actual %h", $time,
                             want.distance, o_result.distance);
                if (o_result.point_x !== want.point_x)
                    $display("%0t: point_x expected %h actual %h", $time,
                             want.point_x, o_result.point_x);
                if (o_result.point_y !== want.point_y)
                    $display("%0t: point_y expected %h actual %h", $time,
                             want.point_y, o_result.point_y);
                if (o_result.point_z !== want.point_z)
                    $display("%0t: point_z expected %h actual %h", $time,
                             want.point_z, o_result.point_z);
                if (o_result.face !== want.face)
                    $display("%0t: face expected %0d actual %0d", $time,
                             want.face, o_result.face);
                if (o_result !== want) error_count++;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] tol_set[4];
        logic [CFG_W-1:0] sub_set[4];
        t_in_item it;
        tol_set = '{17'd0, 17'h1_0000, 17'd16, 17'd300};
        sub_set = '{17'd1, 17'h1_0000, 17'd0, 17'd77};
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        hit_count = 0;
        tolerance = TOL_RESET;
        substitute = SUB_RESET;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IDX_TOL;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: axis rays, zero directions, misses, behind, inside, extremes
        ray_queue.push_back(unit_ray('0, 32'sh0001_0000, '0, '0));
        ray_queue.push_back(unit_ray('0, -32'sh0001_0000, '0, '0));
        ray_queue.push_back(unit_ray(32'sh0002_0000, 32'sh0001_0000, '0, '0));
        ray_queue.push_back(unit_ray(32'sh0005_0000, 32'sh0001_0000, '0, '0));
        ray_queue.push_back(unit_ray(32'sh0005_0000, -32'sh0001_0000, '0, '0));
        ray_queue.push_back(unit_ray(32'sh0002_0000, '0, '0, '0));
        ray_queue.push_back(unit_ray('0, '0, '0, '0));
        ray_queue.push_back(unit_ray('0, 32'sh0001_0000, 32'sh0000_8000, '0));
        ray_queue.push_back(unit_ray('0, 32'sh0000_0001, '0, '0));
        ray_queue.push_back(unit_ray('0, COORD_MAX, COORD_MIN, '0));
        ray_queue.push_back(unit_ray(COORD_MIN, COORD_MAX, '0, 32'sh0000_0001));
        ray_queue.push_back(unit_ray(COORD_MAX, COORD_MIN, '0, -32'sh0000_0001));
        it = unit_ray('0, 32'sh0001_0000, '0, '0);
        it.box_min_x = 32'sh0003_0000;
        it.box_max_x = 32'sh0001_0000;
        ray_queue.push_back(it);
        it = t_in_item'({12{COORD_MAX}});
        ray_queue.push_back(it);
        it = t_in_item'({12{COORD_MIN}});
        ray_queue.push_back(it);
        it = t_in_item'({12{32'hFFFF_FFFF}});
        ray_queue.push_back(it);
        it = t_in_item'({6{COORD_MIN, COORD_MAX}});
        ray_queue.push_back(it);
        it = t_in_item'({6{COORD_MAX, COORD_MIN}});
        ray_queue.push_back(it);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_IDX_TOL, tol_set[ph]);
            write_reg(CFG_IDX_SUB, sub_set[ph]);
            ray_queue.push_back(unit_ray('0, 32'sh0001_0000, '0, '0));
            ray_queue.push_back(unit_ray(32'sh0002_0000, '0, '0, '0));
            for (int n = 0; n < 150; n++) begin
                ray_queue.push_back(($urandom_range(0, 3) != 0) ? aimed_ray() : noise_ray());
            end
            drain();
        end

        $display("sent %0d ray/box tests over five register settings", sent_count);
        $display("checked %0d results, %0d hits", checked_count, hit_count);
        if (error_count == 0) begin
            $display("ray_box_slab_test_unit regression: pass");
        end else begin
            $display("ray_box_slab_test_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("ray_box_slab_test_unit regression: fail");
        $finish;
    end

endmodule
